FILE: src/rhr_pkg.sv
// Shared types and constants for the receive-ring header release block.
// No dependencies; used by every module under src.
package rhr_pkg;

  localparam int ADDR_BITS_DEF = 13;
  localparam int LEN_W         = 16;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 16;
  localparam int QUEUE_DEPTH   = 2;

  // Header constants
  localparam int          RX_OK_BIT = 7;
  localparam logic [15:0] CRC_BYTES = 16'd4;

  // Register reset values
  localparam logic [15:0] RING_START_RESET   = 16'd0;
  localparam logic [15:0] RING_END_RESET     = 16'd6655;
  localparam logic [15:0] CALLER_LIMIT_RESET = 16'd1518;
  localparam logic [15:0] BOUNCE_LIMIT_RESET = 16'd614;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RING_START   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RING_END     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CALLER_LIMIT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_LIMIT = 8'd3;

  // Opcodes
  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_DROP    = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NONE       = 3'd1,
    ST_BAD_PTR    = 3'd2,
    ST_NOT_OK     = 3'd3,
    ST_OVER_CALLER = 3'd4,
    ST_OVER_BOUNCE = 3'd5
  } rhr_status_t;

  // Item class decided by the front end
  typedef enum logic [1:0] {
    CLS_DROP    = 2'd0,
    CLS_NONE    = 2'd1,
    CLS_BAD_PTR = 2'd2,
    CLS_RECEIVE = 2'd3
  } rhr_class_t;

  typedef struct packed {
    rhr_class_t        cls;
    logic              stat_ok;
    logic [LEN_W-1:0]  len;
  } rhr_item_t;

endpackage

FILE: src/rhr_front.sv
// Front end: accepts headers, classifies them and advances the head pointer.
// Depends on rhr_pkg.
module rhr_front #(
  parameter int ADDR_BITS = rhr_pkg::ADDR_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    opcode,
  input  logic                    packet_waiting,
  input  logic [15:0]             hdr_next,
  input  logic [15:0]             hdr_count,
  input  logic [15:0]             hdr_status,
  input  logic [ADDR_BITS-1:0]    ring_start,
  input  logic [ADDR_BITS-1:0]    ring_end,
  input  logic                    q_full,
  output logic                    push,
  output rhr_pkg::rhr_item_t      item,
  output logic [ADDR_BITS-1:0]    read_start,
  output logic [ADDR_BITS-1:0]    rel_base
);
  import rhr_pkg::*;

  logic [ADDR_BITS-1:0] head_pointer;
  logic [ADDR_BITS-1:0] head_pointer_next;
  logic [15:0]          start_ext;
  logic [15:0]          end_ext;
  logic                 in_range;
  logic                 eq_start;
  logic [ADDR_BITS-1:0] next_addr;

  assign in_ready   = !q_full;
  assign push       = in_valid && !q_full;
  assign read_start = head_pointer;

  assign start_ext = 16'(ring_start);
  assign end_ext   = 16'(ring_end);
  assign in_range  = (hdr_next >= start_ext) && (hdr_next <= end_ext);
  assign eq_start  = (hdr_next == start_ext);
  assign next_addr = hdr_next[ADDR_BITS-1:0];

  // Release base before the odd fix-up: next minus one, else ring end
  assign rel_base = (in_range && !eq_start) ? (next_addr - ADDR_BITS'(1)) : ring_end;

  always_comb begin
    item.len     = hdr_count - CRC_BYTES;
    item.stat_ok = hdr_status[RX_OK_BIT];
    head_pointer_next = head_pointer;
    if (opcode == OP_DROP) begin
      item.cls = CLS_DROP;
      head_pointer_next = in_range ? next_addr : ring_start;
    end else if (!packet_waiting) begin
      item.cls = CLS_NONE;
    end else if (!in_range) begin
      item.cls = CLS_BAD_PTR;
      head_pointer_next = ring_start;
    end else begin
      item.cls = CLS_RECEIVE;
      head_pointer_next = next_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_pointer <= '0;
    end else if (push) begin
      head_pointer <= head_pointer_next;
    end
  end

endmodule

FILE: src/rhr_queue.sv
// Short FIFO between the front end and the back end.
// Depends on rhr_pkg for the default depth.
module rhr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rhr_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: src/rhr_back.sv
// Back end: limit checks, odd release pointer and the registered result.
// Depends on rhr_pkg.
module rhr_back #(
  parameter int ADDR_BITS = rhr_pkg::ADDR_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  output logic                    pop,
  input  rhr_pkg::rhr_item_t      item,
  input  logic [ADDR_BITS-1:0]    q_read_start,
  input  logic [ADDR_BITS-1:0]    rel_base,
  input  logic [ADDR_BITS-1:0]    ring_start,
  input  logic [ADDR_BITS-1:0]    ring_end,
  input  logic [15:0]             caller_limit,
  input  logic [15:0]             bounce_limit,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [15:0]             payload_len,
  output logic [2:0]              status_code,
  output logic [ADDR_BITS-1:0]    read_start,
  output logic [ADDR_BITS-1:0]    release_ptr,
  output logic                    release_valid,
  output logic                    count_decrement
);
  import rhr_pkg::*;

  logic [15:0]          plen_next;
  rhr_status_t          code_next;
  logic [ADDR_BITS-1:0] rel_next;
  logic                 rvalid_next;
  logic                 dec_next;
  logic [ADDR_BITS-1:0] rel_odd;

  // Step an even pointer down by one; ring start maps to ring end
  assign rel_odd = rel_base[0] ? rel_base :
                   (rel_base == ring_start) ? ring_end : (rel_base - ADDR_BITS'(1));

  assign pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    plen_next   = '0;
    code_next   = ST_OK;
    rel_next    = '0;
    rvalid_next = 1'b0;
    dec_next    = 1'b0;
    case (item.cls)
      CLS_DROP: begin
        rel_next    = rel_odd;
        rvalid_next = 1'b1;
        dec_next    = 1'b1;
      end
      CLS_NONE: begin
        code_next = ST_NONE;
      end
      CLS_BAD_PTR: begin
        code_next = ST_BAD_PTR;
        dec_next  = 1'b1;
      end
      CLS_RECEIVE: begin
        rel_next    = rel_odd;
        rvalid_next = 1'b1;
        dec_next    = 1'b1;
        if (!item.stat_ok) begin
          code_next = ST_NOT_OK;
        end else if (item.len > caller_limit) begin
          code_next = ST_OVER_CALLER;
        end else if (item.len > bounce_limit) begin
          code_next = ST_OVER_BOUNCE;
        end else begin
          plen_next = item.len;
        end
      end
      default: begin
        code_next = ST_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      payload_len     <= plen_next;
      status_code     <= code_next;
      read_start      <= q_read_start;
      release_ptr     <= rel_next;
      release_valid   <= rvalid_next;
      count_decrement <= dec_next;
    end
  end

endmodule

FILE: src/rx_ring_header_release_top.sv
// Top level of the receive-ring header release block: config registers,
// front end, queue and back end. Depends on rhr_pkg, rhr_front, rhr_queue, rhr_back.
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------------------------
//   in      | in_valid / in_ready   | opcode, packet_waiting, hdr_next,
//           |                       | hdr_count, hdr_status
//   out     | out_valid / out_ready | payload_len, status_code, read_start,
//           |                       | release_ptr, release_valid, count_decrement
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per cycle sustained while out_ready stays high; an accepted request
// is written into the queue and then popped into the output register, where it
// waits for out_ready.
// The head pointer register in the front end updates in the cycle of acceptance.
// Reset clears the head pointer, the queue and the output valid, and restores
// the register defaults. The two-entry queue lets the input keep accepting while
// a result waits for out_ready; in_ready drops only when the queue is full.
// cfg_ready is always high; writes to an unknown index are ignored.
module rx_ring_header_release_top #(
  parameter int ADDR_BITS = rhr_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rhr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rhr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic                          packet_waiting,
  input  logic [15:0]                   hdr_next,
  input  logic [15:0]                   hdr_count,
  input  logic [15:0]                   hdr_status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   payload_len,
  output logic [2:0]                    status_code,
  output logic [ADDR_BITS-1:0]          read_start,
  output logic [ADDR_BITS-1:0]          release_ptr,
  output logic                          release_valid,
  output logic                          count_decrement
);
  import rhr_pkg::*;

  localparam int ITEM_W  = $bits(rhr_item_t);
  localparam int ENTRY_W = ITEM_W + 2 * ADDR_BITS;

  // Configuration registers
  logic [ADDR_BITS-1:0] ring_start;
  logic [ADDR_BITS-1:0] ring_end;
  logic [15:0]          caller_limit;
  logic [15:0]          bounce_limit;

  // Front end to queue
  logic                 push;
  logic                 q_full;
  rhr_item_t            f_item;
  logic [ADDR_BITS-1:0] f_read_start;
  logic [ADDR_BITS-1:0] f_rel_base;
  logic [ENTRY_W-1:0]   push_data;

  // Queue to back end
  logic                 pop;
  logic                 q_valid;
  logic [ENTRY_W-1:0]   pop_data;
  rhr_item_t            b_item;
  logic [ADDR_BITS-1:0] b_read_start;
  logic [ADDR_BITS-1:0] b_rel_base;

  assign cfg_ready = 1'b1;

  // Take a config write; ring addresses keep the low ADDR_BITS bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_start   <= RING_START_RESET[ADDR_BITS-1:0];
      ring_end     <= RING_END_RESET[ADDR_BITS-1:0];
      caller_limit <= CALLER_LIMIT_RESET;
      bounce_limit <= BOUNCE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RING_START:   ring_start   <= cfg_data[ADDR_BITS-1:0];
        REG_RING_END:     ring_end     <= cfg_data[ADDR_BITS-1:0];
        REG_CALLER_LIMIT: caller_limit <= cfg_data;
        REG_BOUNCE_LIMIT: bounce_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rhr_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .packet_waiting (packet_waiting),
    .hdr_next       (hdr_next),
    .hdr_count      (hdr_count),
    .hdr_status     (hdr_status),
    .ring_start     (ring_start),
    .ring_end       (ring_end),
    .q_full         (q_full),
    .push           (push),
    .item           (f_item),
    .read_start     (f_read_start),
    .rel_base       (f_rel_base)
  );

  // Pack the classified request with its pointers for the queue
  assign push_data = {f_item, f_read_start, f_rel_base};

  rhr_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_data  (pop_data)
  );

  assign b_item       = rhr_item_t'(pop_data[ENTRY_W-1 -: ITEM_W]);
  assign b_read_start = pop_data[2*ADDR_BITS-1 -: ADDR_BITS];
  assign b_rel_base   = pop_data[ADDR_BITS-1:0];

  rhr_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .pop             (pop),
    .item            (b_item),
    .q_read_start    (b_read_start),
    .rel_base        (b_rel_base),
    .ring_start      (ring_start),
    .ring_end        (ring_end),
    .caller_limit    (caller_limit),
    .bounce_limit    (bounce_limit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .payload_len     (payload_len),
    .status_code     (status_code),
    .read_start      (read_start),
    .release_ptr     (release_ptr),
    .release_valid   (release_valid),
    .count_decrement (count_decrement)
  );

endmodule

FILE: tb/sv/rx_ring_header_release_top_tb.sv
// Self-checking testbench for rx_ring_header_release_top: directed and random header traffic,
// register sweeps and random stalls on both channels, scored against an in-bench predictor.
// Depends on rhr_pkg and the RTL under src; needs no files or arguments.
`timescale 1ns / 1ps

module rx_ring_header_release_top_tb;
  import rhr_pkg::*;

  localparam int AW          = ADDR_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_IDLE    = 14;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 150;

  // Indexes past the end of the register map; writes to them must not land anywhere.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP = 8'hFF;

  // One release result as the block presents it.
  typedef struct packed {
    logic [LEN_W-1:0] plen;
    rhr_status_t      code;
    logic [AW-1:0]    rstart;
    logic [AW-1:0]    rel;
    logic             rvalid;
    logic             dec;
  } release_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  opcode;
  logic                  packet_waiting;
  logic [15:0]           hdr_next;
  logic [15:0]           hdr_count;
  logic [15:0]           hdr_status;
  logic                  out_valid;
  logic                  out_ready;
  logic [15:0]           payload_len;
  logic [2:0]            status_code;
  logic [AW-1:0]         read_start;
  logic [AW-1:0]         release_ptr;
  logic                  release_valid;
  logic                  count_decrement;

  // Predictor copy of the registers and the ring head.
  logic [AW-1:0]    ring_start;
  logic [AW-1:0]    ring_end;
  logic [LEN_W-1:0] caller_lim;
  logic [LEN_W-1:0] bounce_lim;
  logic [AW-1:0]    head_ptr;

  release_result_t expected_releases[$];

  int          err_count   = 0;
  int          cycle_count = 0;
  int unsigned out_hold    = 0;     // cycles the receiver still holds off
  bit          in_steady   = 1'b0;  // sender issues back to back
  bit          out_steady  = 1'b0;  // receiver never stalls
  int unsigned chain_ptr;           // sender-side walk around the ring

  rx_ring_header_release_top #(
    .ADDR_BITS(AW)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .packet_waiting (packet_waiting),
    .hdr_next       (hdr_next),
    .hdr_count      (hdr_count),
    .hdr_status     (hdr_status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .payload_len    (payload_len),
    .status_code    (status_code),
    .read_start     (read_start),
    .release_ptr    (release_ptr),
    .release_valid  (release_valid),
    .count_decrement(count_decrement)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Force the release pointer odd: step an even value down by one, except that a
  // value sitting on ring_start folds to ring_end, which may stay even. The step
  // down wraps at the address width.
  function automatic logic [AW-1:0] odd_release_ptr(int unsigned p);
    int unsigned q;
    q = p;
    if ((q & 1) == 0) begin
      q = (q == ring_start) ? int'(ring_end) : ((q - 1) & ((1 << AW) - 1));
    end
    return AW'(q);
  endfunction

  // Work out the result of one accepted header and advance the head.
  function automatic release_result_t predict_release(logic op, logic wt,
                                                      logic [15:0] nxt, logic [15:0] cnt,
                                                      logic [15:0] sts);
    release_result_t r;
    int unsigned     nx;
    int unsigned     rel;
    logic [15:0]     len;
    r.plen   = '0;
    r.code   = ST_OK;
    r.rstart = head_ptr;
    r.rel    = '0;
    r.rvalid = 1'b0;
    r.dec    = 1'b0;
    nx       = nxt;
    if (op == OP_DROP) begin
      // Drop ignores waiting, count and status; a wild pointer restarts the ring.
      if (nx == ring_start) begin
        rel = ring_end;
      end else if (nx > ring_start && nx <= ring_end) begin
        rel = nx - 1;
      end else begin
        nx  = ring_start;
        rel = ring_end;
      end
      r.rel    = odd_release_ptr(rel);
      head_ptr = AW'(nx);
      r.rvalid = 1'b1;
      r.dec    = 1'b1;
    end else if (!wt) begin
      r.code = ST_NONE;
    end else if (nx < ring_start || nx > ring_end) begin
      r.code   = ST_BAD_PTR;
      head_ptr = ring_start;
      r.dec    = 1'b1;
    end else begin
      len = cnt - CRC_BYTES;
      if (!sts[RX_OK_BIT]) begin
        r.code = ST_NOT_OK;
      end else if (len > caller_lim) begin
        r.code = ST_OVER_CALLER;
      end else if (len > bounce_lim) begin
        r.code = ST_OVER_BOUNCE;
      end else begin
        r.plen = len;
      end
      head_ptr = AW'(nx);
      rel      = (nx == ring_start) ? int'(ring_end) : nx - 1;
      r.rel    = odd_release_ptr(rel);
      r.rvalid = 1'b1;
      r.dec    = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard: everything sampled at the rising edge
  // ---------------------------------------------------------------------------

  task automatic report_failure(string msg);
    if (err_count < 10) begin
      $display("%s", msg);
    end
    err_count++;
  endtask

  always @(posedge clk) begin : release_monitor
    release_result_t want;
    release_result_t got;
    if (!rst) begin
      // Track register writes so the predictor sees the same settings.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RING_START:   ring_start = cfg_data[AW-1:0];
          REG_RING_END:     ring_end   = cfg_data[AW-1:0];
          REG_CALLER_LIMIT: caller_lim = cfg_data[LEN_W-1:0];
          REG_BOUNCE_LIMIT: bounce_lim = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_releases.push_back(predict_release(opcode, packet_waiting, hdr_next,
                                                    hdr_count, hdr_status));
      end
      if (out_valid && out_ready) begin
        // Draw the receiver's hold-off for the next result.
        out_hold    = out_steady ? 0 : $urandom_range(MAX_IDLE);
        got.plen    = payload_len;
        got.code    = rhr_status_t'(status_code);
        got.rstart  = read_start;
        got.rel     = release_ptr;
        got.rvalid  = release_valid;
        got.dec     = count_decrement;
        if (expected_releases.size() == 0) begin
          report_failure($sformatf("cycle %0d: result with nothing expected", cycle_count));
        end else begin
          want = expected_releases.pop_front();
          if (got.plen !== want.plen || got.code !== want.code ||
              got.rstart !== want.rstart || got.rel !== want.rel ||
              got.rvalid !== want.rvalid || got.dec !== want.dec) begin
            report_failure({
              $sformatf("cycle %0d mismatch (exp/act): len %0d/%0d code %0d/%0d",
                        cycle_count, want.plen, got.plen, want.code, got.code),
              $sformatf(" start %0d/%0d rel %0d/%0d rv %b/%b dec %b/%b",
                        want.rstart, got.rstart, want.rel, got.rel,
                        want.rvalid, got.rvalid, want.dec, got.dec)});
          end
        end
      end
    end
  end

  // Receiver: drop ready for the drawn number of cycles after each result, then hold it high.
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers: inputs change on the falling edge
  // ---------------------------------------------------------------------------

  // Send one header request. Valid stays up after acceptance so a zero gap gives
  // back to back requests; a nonzero gap lowers it on the first falling edge.
  task automatic send_header(logic op, logic wt, logic [15:0] nxt, logic [15:0] cnt,
                             logic [15:0] sts);
    int unsigned gap;
    gap = in_steady ? 0 : $urandom_range(MAX_IDLE);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    opcode         <= op;
    packet_waiting <= wt;
    hdr_next       <= nxt;
    hdr_count      <= cnt;
    hdr_status     <= sts;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold until every outstanding result has been checked.
  task automatic drain_releases();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_releases.size() != 0) @(posedge clk);
  endtask

  // Write one register; only called with the block idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Program the whole register set. Ring writes carry random bits above the
  // address width, which the block must mask off.
  task automatic configure_ring(int unsigned rs, int unsigned re, int unsigned cl,
                                int unsigned bl);
    logic [CFG_DATA_W-1:0] data;
    data         = CFG_DATA_W'($urandom);
    data[AW-1:0] = AW'(rs);
    write_reg(REG_RING_START, data);
    data         = CFG_DATA_W'($urandom);
    data[AW-1:0] = AW'(re);
    write_reg(REG_RING_END, data);
    write_reg(REG_CALLER_LIMIT, CFG_DATA_W'(cl));
    write_reg(REG_BOUNCE_LIMIT, CFG_DATA_W'(bl));
    chain_ptr = rs;
  endtask

  // Draw one header. Half of the requests walk the ring like a real receive stream with
  // lengths near the limits; the rest land on or just past the ring edges, anywhere in the ring, or are plain noise.
  task automatic send_random_header();
    logic        op;
    logic        wt;
    logic [15:0] nxt;
    logic [15:0] cnt;
    logic [15:0] sts;
    int unsigned span;
    int unsigned lim_lo;
    op  = ($urandom_range(4) == 0) ? OP_DROP : OP_RECEIVE;
    wt  = ($urandom_range(9) != 0);
    sts = 16'($urandom);
    sts[RX_OK_BIT] = ($urandom_range(6) != 0);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        if (ring_start <= ring_end) begin
          span = ring_end - ring_start + 1;
          if (chain_ptr < ring_start || chain_ptr > ring_end) chain_ptr = ring_start;
          chain_ptr = ring_start + (chain_ptr - ring_start + $urandom_range(1600, 1)) % span;
          nxt = 16'(chain_ptr);
        end else begin
          nxt = 16'($urandom_range((1 << AW) - 1));
        end
      end
      5:       nxt = 16'(ring_start);
      6:       nxt = 16'(ring_end);
      7:       nxt = $urandom_range(1) ? 16'(ring_start - 1) : 16'(ring_end + 1);
      8:       nxt = 16'($urandom);
      default: nxt = 16'($urandom_range(ring_end, ring_start));
    endcase
    lim_lo = (caller_lim < bounce_lim) ? caller_lim : bounce_lim;
    case ($urandom_range(9))
      0, 1, 2, 3: cnt = 16'($urandom_range(lim_lo) + 4);
      4:          cnt = 16'(caller_lim + 4 + $urandom_range(1));
      5:          cnt = 16'(bounce_lim + 4 + $urandom_range(1));
      6:          cnt = 16'($urandom_range(3));
      7:          cnt = 16'($urandom_range(caller_lim, bounce_lim) + 4);
      default:    cnt = 16'($urandom);
    endcase
    send_header(op, wt, nxt, cnt, sts);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: ring 0..6655, caller 1518, bounce 614.
  task automatic test_defaults_directed();
    in_steady  = 1'b0;
    out_steady = 1'b0;
    // nothing waiting, every header bit high
    send_header(OP_RECEIVE, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // clean receive, even next gives an odd release
    send_header(OP_RECEIVE, 1'b1, 16'd100, 16'd68, 16'h0080);
    // zero length payload; odd next releases an even value that steps down
    send_header(OP_RECEIVE, 1'b1, 16'd201, 16'd4, 16'h0080);
    // next on ring start releases ring end; length right at the bounce limit
    send_header(OP_RECEIVE, 1'b1, 16'd0, 16'd618, 16'h0080);
    // next on ring end; one past the bounce limit
    send_header(OP_RECEIVE, 1'b1, 16'd6655, 16'd619, 16'hFFFF);
    // pointers just past the ring and at the top of the field
    send_header(OP_RECEIVE, 1'b1, 16'd6656, 16'd100, 16'h0080);
    send_header(OP_RECEIVE, 1'b1, 16'hFFFF, 16'd100, 16'h0080);
    // received-ok bit clear with everything else set
    send_header(OP_RECEIVE, 1'b1, 16'd300, 16'd100, 16'hFF7F);
    // one past the caller limit, then right at it (bounce check fails)
    send_header(OP_RECEIVE, 1'b1, 16'd400, 16'd1523, 16'h0080);
    send_header(OP_RECEIVE, 1'b1, 16'd500, 16'd1522, 16'h0080);
    // counts shorter than the CRC wrap to huge lengths
    send_header(OP_RECEIVE, 1'b1, 16'd600, 16'd0, 16'h0080);
    send_header(OP_RECEIVE, 1'b1, 16'd601, 16'd3, 16'h0080);
    // release lands on ring start and folds to ring end
    send_header(OP_RECEIVE, 1'b1, 16'd1, 16'd64, 16'h0080);
    // drop: in range, on start, wild pointer, fold to end, top of field
    send_header(OP_DROP, 1'b0, 16'd50, 16'hFFFF, 16'h0000);
    send_header(OP_DROP, 1'b1, 16'd0, 16'd0, 16'h0000);
    send_header(OP_DROP, 1'b0, 16'd7000, 16'd0, 16'hFFFF);
    send_header(OP_DROP, 1'b1, 16'd1, 16'd20, 16'h0080);
    send_header(OP_DROP, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain_releases();
  endtask

  // Unmapped register writes, a one-entry even ring and a misconfigured ring.
  task automatic test_ring_corners();
    // writes past the map must leave the defaults alone
    write_reg(REG_UNMAPPED, 16'h0000);
    write_reg(REG_INDEX_TOP, 16'hFFFF);
    send_header(OP_RECEIVE, 1'b1, 16'd6655, 16'd1522, 16'h0080);
    drain_releases();
    // start equals end on an even address: the fold keeps the release even
    configure_ring(100, 100, 1518, 614);
    send_header(OP_DROP, 1'b1, 16'd100, 16'd64, 16'h0080);
    send_header(OP_RECEIVE, 1'b1, 16'd100, 16'd64, 16'h0080);
    send_header(OP_RECEIVE, 1'b1, 16'd101, 16'd64, 16'h0080);
    drain_releases();
    // start above end: no receive pointer fits, drop falls back; end 0 wraps the release
    configure_ring(5, 0, 1518, 614);
    send_header(OP_DROP, 1'b1, 16'd5, 16'd64, 16'h0080);
    send_header(OP_DROP, 1'b0, 16'd3000, 16'd64, 16'h0080);
    send_header(OP_RECEIVE, 1'b1, 16'd5, 16'd64, 16'h0080);
    send_header(OP_RECEIVE, 1'b0, 16'd5, 16'd64, 16'h0080);
    drain_releases();
  endtask

  // Random traffic over a sweep of register settings. Each phase drains fully
  // before reprogramming, so the sender also pauses until every result is in.
  task automatic test_random_traffic();
    int unsigned rs;
    int unsigned re;
    int unsigned cl;
    int unsigned bl;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 7)
        0: begin  // reset values
          rs = RING_START_RESET; re = RING_END_RESET;
          cl = CALLER_LIMIT_RESET; bl = BOUNCE_LIMIT_RESET;
        end
        1: begin  // whole address space, widest limits
          rs = 0; re = (1 << AW) - 1; cl = 16'hFFFF; bl = 16'hFFFF;
        end
        2: begin  // single top entry, zero limits
          rs = (1 << AW) - 1; re = (1 << AW) - 1; cl = 0; bl = 0;
        end
        3: begin  // small ring anywhere
          rs = $urandom_range(8000); re = rs + $urandom_range(150, 1);
          cl = $urandom_range(16'hFFFF); bl = $urandom_range(16'hFFFF);
        end
        4: begin  // misconfigured ring
          rs = $urandom_range((1 << AW) - 1, 100); re = $urandom_range(rs - 1);
          cl = $urandom_range(16'hFFFF); bl = $urandom_range(16'hFFFF);
        end
        5: begin  // caller limit at or below bounce limit
          rs = $urandom_range(4000); re = $urandom_range((1 << AW) - 1, rs);
          cl = $urandom_range(2000); bl = cl + $urandom_range(3000);
        end
        default: begin
          rs = $urandom_range((1 << AW) - 1); re = $urandom_range((1 << AW) - 1);
          cl = $urandom_range(16'hFFFF); bl = $urandom_range(16'hFFFF);
        end
      endcase
      configure_ring(rs, re, cl, bl);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // re-pick the idling mode every 30 requests; some stretches run flat out
        if (n % 30 == 0) begin
          in_steady  = ($urandom_range(3) == 0);
          out_steady = ($urandom_range(3) == 0);
        end
        send_random_header();
      end
      drain_releases();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    opcode         = OP_RECEIVE;
    packet_waiting = 1'b0;
    hdr_next       = '0;
    hdr_count      = '0;
    hdr_status     = '0;
    out_ready      = 1'b0;
    // predictor starts from the reset register set and a zero head
    ring_start     = RING_START_RESET[AW-1:0];
    ring_end       = RING_END_RESET[AW-1:0];
    caller_lim     = CALLER_LIMIT_RESET;
    bounce_lim     = BOUNCE_LIMIT_RESET;
    head_ptr       = '0;
    chain_ptr      = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_defaults_directed();
    test_ring_corners();
    test_random_traffic();

    // hold a little longer to catch any stray result
    drain_releases();
    repeat (8) @(posedge clk);
    if (expected_releases.size() != 0) begin
      report_failure($sformatf("%0d results never arrived", expected_releases.size()));
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/rhr_pkg.sv
src/rhr_front.sv
src/rhr_queue.sv
src/rhr_back.sv
src/rx_ring_header_release_top.sv
tb/sv/rx_ring_header_release_top_tb.sv
